/* hdl/y86_pkg.sv */
// Shared constants, codes and controller/datapath types for the Y86-64 step core.
package y86_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int AW        = $clog2(MEM_BYTES);
    localparam int NREGS     = 15;

    typedef enum logic [1:0] {
        ST_AOK = 2'd0,
        ST_HLT = 2'd1,
        ST_ADR = 2'd2,
        ST_INS = 2'd3
    } stat_t;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_EXEC = 2'd1,
        REQ_RREG = 2'd2,
        REQ_RDQ  = 2'd3
    } req_t;

    localparam logic [3:0] I_HALT  = 4'h0;
    localparam logic [3:0] I_NOP   = 4'h1;
    localparam logic [3:0] I_CMOV  = 4'h2;
    localparam logic [3:0] I_IRMOV = 4'h3;
    localparam logic [3:0] I_RMMOV = 4'h4;
    localparam logic [3:0] I_MRMOV = 4'h5;
    localparam logic [3:0] I_OPQ   = 4'h6;
    localparam logic [3:0] I_JXX   = 4'h7;
    localparam logic [3:0] I_CALL  = 4'h8;
    localparam logic [3:0] I_RET   = 4'h9;
    localparam logic [3:0] I_PUSH  = 4'hA;
    localparam logic [3:0] I_POP   = 4'hB;

    localparam logic [3:0] F_ADD = 4'h0;
    localparam logic [3:0] F_SUB = 4'h1;
    localparam logic [3:0] F_AND = 4'h2;
    localparam logic [3:0] F_XOR = 4'h3;
    localparam logic [3:0] F_LAST_ALU  = 4'h3;
    localparam logic [3:0] F_LAST_COND = 4'h6;

    localparam logic [3:0] R_SP   = 4'h4;
    localparam logic [3:0] R_NONE = 4'hF;

    typedef enum logic [4:0] {
        CS_CLEAR,
        CS_IDLE,
        CS_LOAD,
        CS_RDQ,
        CS_FETCH0,
        CS_DECODE,
        CS_FREG,
        CS_FCONST,
        CS_READA,
        CS_READB,
        CS_EXEC,
        CS_MEMCHK,
        CS_MEMRD,
        CS_MEMWR,
        CS_WBACK,
        CS_RESP
    } state_t;

    typedef enum logic [2:0] {
        EB_REQ,
        EB_PC,
        EB_PC1,
        EB_CONST,
        EB_DATA
    } eng_base_t;

    typedef enum logic {
        ED_LOAD,
        ED_STORE
    } eng_data_t;

    typedef enum logic [1:0] {
        RS_PROBE,
        RS_SRCA,
        RS_SRCB
    } rd_sel_t;

    typedef struct packed {
        logic      clr_run;
        logic      req_latch;
        logic      eng_start;
        logic      eng_write;
        logic [3:0] eng_n;
        eng_base_t eng_base;
        eng_data_t eng_data;
        rd_sel_t   rd_sel;
        logic      rv_reg_ld;
        logic      rv_word_ld;
        logic      latch_ibyte;
        logic      latch_rbyte;
        logic      latch_valc;
        logic      latch_vala;
        logic      latch_valb;
        logic      latch_exec;
        logic      latch_valm;
        logic      wback;
        logic      set_stat;
        stat_t     new_stat;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic eng_done;
        logic stat_ok;
        logic pc_oob;
        logic icode_bad;
        logic fetch_oob;
        logic halt;
        logic fun_bad;
        logic has_regs;
        logic need_c;
        logic mem_use;
        logic mem_rd;
        logic data_oob;
    } dp_sts_t;

endpackage

/* hdl/y86_req_if.sv */
// Request channel: one item per request, valid/ready handshake.
interface y86_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  load_data;
    logic [3:0]  probe_reg;

    modport source (output valid, req_type, address, load_data, probe_reg, input ready);
    modport sink (input valid, req_type, address, load_data, probe_reg, output ready);
endinterface

/* hdl/y86_rsp_if.sv */
// Response channel: one result item per request, valid/ready handshake.
interface y86_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [63:0]        prog_counter;
    logic               zero_flag;
    logic               sign_flag;
    logic               overflow_flag;
    logic signed [63:0] read_value;
    logic               read_error;

    modport source (output valid, status, prog_counter, zero_flag, sign_flag, overflow_flag,
                    read_value, read_error, input ready);
    modport sink (input valid, status, prog_counter, zero_flag, sign_flag, overflow_flag,
                  read_value, read_error, output ready);
endinterface

/* hdl/y86_dp.sv */
// Datapath: byte memory with its access engine, register file, ALU and architectural state.
module y86_dp
    import y86_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    input  logic [15:0]        address,
    input  logic [7:0]         load_data,
    input  logic [3:0]         probe_reg,
    output logic [1:0]         status,
    output logic [63:0]        prog_counter,
    output logic               zero_flag,
    output logic               sign_flag,
    output logic               overflow_flag,
    output logic signed [63:0] read_value,
    output logic               read_error
);

    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  memq_reg;
    logic [AW-1:0] mem_addr;
    logic [7:0]  mem_wd;
    logic        mem_we;
    logic [AW-1:0] clr_cnt_reg;

    logic [63:0] rf_reg [NREGS];
    logic [63:0] pc_reg;
    logic [2:0]  cc_reg;    // {of, sf, zf}
    stat_t       stat_reg;
    logic [7:0]  ibyte_reg, rbyte_reg;
    logic [63:0] valc_reg, vala_reg, valb_reg, vale_reg, valm_reg, rv_reg;
    logic        cnd_reg, err_reg;
    logic [2:0]  ccn_reg;

    logic [63:0] eng_base_reg, word_reg;
    logic [3:0]  eng_n_reg, iss_cnt_reg, cap_cnt_reg;
    logic        eng_wr_reg, eng_act_reg, pend_reg, pok_reg;

    logic [3:0]  icode, ifun, ra, rb, len, src_a, src_b, dst_e, dst_m, rd_idx;
    logic [63:0] eng_p, base_sel, data_sel, valp, maddr, rd_val, vale_next, newpc;
    logic        eng_ok, issuing, eng_done, cnd_next, ofl, lt;
    logic        has_regs, has_const;
    logic [2:0]  ccn_next;

    assign icode = ibyte_reg[7:4];
    assign ifun  = ibyte_reg[3:0];
    assign ra    = rbyte_reg[7:4];
    assign rb    = rbyte_reg[3:0];

    always_comb
    begin
        has_regs  = icode inside {I_CMOV, I_IRMOV, I_RMMOV, I_MRMOV, I_OPQ, I_PUSH, I_POP};
        has_const = icode inside {I_IRMOV, I_RMMOV, I_MRMOV, I_JXX, I_CALL};
        len = 4'd1 + {3'd0, has_regs} + (has_const ? 4'd8 : 4'd0);
        valp = pc_reg + {60'd0, len};

        src_a = R_NONE;
        src_b = R_NONE;
        if (icode inside {I_CMOV, I_RMMOV, I_OPQ, I_PUSH})
        begin
            src_a = ra;
        end
        else if (icode inside {I_RET, I_POP})
        begin
            src_a = R_SP;
        end
        if (icode inside {I_RMMOV, I_MRMOV, I_OPQ})
        begin
            src_b = rb;
        end
        else if (icode inside {I_CALL, I_RET, I_PUSH, I_POP})
        begin
            src_b = R_SP;
        end

        dst_e = R_NONE;
        if (icode inside {I_IRMOV, I_OPQ} || (icode == I_CMOV && cnd_reg))
        begin
            dst_e = rb;
        end
        else if (icode inside {I_CALL, I_RET, I_PUSH, I_POP})
        begin
            dst_e = R_SP;
        end
        dst_m = (icode inside {I_MRMOV, I_POP}) ? ra : R_NONE;

        case (cmd.rd_sel)
            RS_PROBE: rd_idx = probe_reg;
            RS_SRCA:  rd_idx = src_a;
            RS_SRCB:  rd_idx = src_b;
            default:  rd_idx = R_NONE;
        endcase
        rd_val = (rd_idx < 4'(NREGS)) ? rf_reg[rd_idx] : 64'd0;

        // Condition evaluation from the current flags.
        lt = cc_reg[1] ^ cc_reg[2];
        case (ifun)
            4'h0:    cnd_next = 1'b1;
            4'h1:    cnd_next = lt | cc_reg[0];
            4'h2:    cnd_next = lt;
            4'h3:    cnd_next = cc_reg[0];
            4'h4:    cnd_next = ~cc_reg[0];
            4'h5:    cnd_next = ~lt;
            4'h6:    cnd_next = ~lt & ~cc_reg[0];
            default: cnd_next = 1'b0;
        endcase

        ofl = 1'b0;
        case (icode)
            I_CMOV:                 vale_next = vala_reg;
            I_IRMOV:                vale_next = valc_reg;
            I_RMMOV, I_MRMOV:       vale_next = valb_reg + valc_reg;
            I_CALL, I_PUSH:         vale_next = valb_reg - 64'd8;
            I_RET, I_POP:           vale_next = valb_reg + 64'd8;
            I_OPQ:
            begin
                case (ifun)
                    F_ADD:
                    begin
                        vale_next = valb_reg + vala_reg;
                        ofl = (vala_reg[63] ^ vale_next[63]) & (valb_reg[63] ^ vale_next[63]);
                    end
                    F_SUB:
                    begin
                        vale_next = valb_reg - vala_reg;
                        ofl = (valb_reg[63] ^ vala_reg[63]) & (valb_reg[63] ^ vale_next[63]);
                    end
                    F_AND:   vale_next = valb_reg & vala_reg;
                    default: vale_next = valb_reg ^ vala_reg;
                endcase
            end
            default:                vale_next = 64'd0;
        endcase
        ccn_next = {ofl, vale_next[63], vale_next == 64'd0};

        maddr = (icode inside {I_RET, I_POP}) ? vala_reg : vale_reg;

        case (icode)
            I_JXX:   newpc = cnd_reg ? valc_reg : valp;
            I_CALL:  newpc = valc_reg;
            I_RET:   newpc = valm_reg;
            default: newpc = valp;
        endcase

        case (cmd.eng_base)
            EB_REQ:   base_sel = {48'd0, address};
            EB_PC:    base_sel = pc_reg;
            EB_PC1:   base_sel = pc_reg + 64'd1;
            EB_CONST: base_sel = pc_reg + (has_regs ? 64'd2 : 64'd1);
            EB_DATA:  base_sel = maddr;
            default:  base_sel = pc_reg;
        endcase
        case (cmd.eng_data)
            ED_LOAD: data_sel = {56'd0, load_data};
            default: data_sel = (icode == I_CALL) ? valp : vala_reg;
        endcase
    end

    // Byte engine: walks eng_n bytes from the base, one issue per cycle.
    assign eng_p    = eng_base_reg + {60'd0, iss_cnt_reg};
    assign eng_ok   = eng_p < 64'(MEM_BYTES);
    assign issuing  = eng_act_reg && (iss_cnt_reg < eng_n_reg);
    assign eng_done = eng_act_reg && (eng_wr_reg ? (iss_cnt_reg == eng_n_reg)
                                                 : (cap_cnt_reg == eng_n_reg));

    assign mem_we   = cmd.clr_run || (issuing && eng_wr_reg && eng_ok);
    assign mem_addr = cmd.clr_run ? clr_cnt_reg : eng_p[AW-1:0];
    assign mem_wd   = cmd.clr_run ? 8'd0 : word_reg[7:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wd;
        end
        memq_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            eng_base_reg <= '0;
            word_reg     <= '0;
            eng_n_reg    <= '0;
            iss_cnt_reg  <= '0;
            cap_cnt_reg  <= '0;
            eng_wr_reg   <= 1'b0;
            eng_act_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            pok_reg      <= 1'b0;
            err_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clr_run)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.req_latch)
            begin
                err_reg <= 1'b0;
            end
            pend_reg <= issuing && !eng_wr_reg;
            pok_reg  <= eng_ok;
            if (cmd.eng_start)
            begin
                eng_base_reg <= base_sel;
                eng_n_reg    <= cmd.eng_n;
                eng_wr_reg   <= cmd.eng_write;
                eng_act_reg  <= 1'b1;
                iss_cnt_reg  <= '0;
                cap_cnt_reg  <= '0;
                word_reg     <= cmd.eng_write ? data_sel : 64'd0;
            end
            else
            begin
                if (eng_done)
                begin
                    eng_act_reg <= 1'b0;
                end
                if (issuing)
                begin
                    iss_cnt_reg <= iss_cnt_reg + 1'b1;
                    if (eng_wr_reg)
                    begin
                        word_reg <= word_reg >> 8;
                        if (!eng_ok)
                        begin
                            err_reg <= 1'b1;
                        end
                    end
                end
                // Read data arrives in the cycle after its address; bytes shift in at the top.
                if (pend_reg)
                begin
                    word_reg    <= {pok_reg ? memq_reg : 8'd0, word_reg[63:8]};
                    cap_cnt_reg <= cap_cnt_reg + 1'b1;
                    if (!pok_reg)
                    begin
                        err_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
            begin
                rf_reg[i] <= '0;
            end
            pc_reg    <= '0;
            cc_reg    <= 3'b001;
            stat_reg  <= ST_AOK;
            ibyte_reg <= '0;
            rbyte_reg <= '0;
            valc_reg  <= '0;
            vala_reg  <= '0;
            valb_reg  <= '0;
            vale_reg  <= '0;
            valm_reg  <= '0;
            cnd_reg   <= 1'b0;
            ccn_reg   <= '0;
            rv_reg    <= '0;
        end
        else
        begin
            if (cmd.rv_reg_ld)
            begin
                rv_reg <= rd_val;
            end
            else if (cmd.rv_word_ld)
            begin
                rv_reg <= word_reg;
            end
            else if (cmd.req_latch)
            begin
                rv_reg <= '0;
            end
            if (cmd.latch_ibyte)
            begin
                ibyte_reg <= word_reg[63:56];
                rbyte_reg <= {R_NONE, R_NONE};
            end
            if (cmd.latch_rbyte)
            begin
                rbyte_reg <= word_reg[63:56];
            end
            if (cmd.latch_valc)
            begin
                valc_reg <= word_reg;
            end
            if (cmd.latch_vala)
            begin
                vala_reg <= rd_val;
            end
            if (cmd.latch_valb)
            begin
                valb_reg <= rd_val;
            end
            if (cmd.latch_exec)
            begin
                vale_reg <= vale_next;
                cnd_reg  <= cnd_next;
                ccn_reg  <= ccn_next;
            end
            if (cmd.latch_valm)
            begin
                valm_reg <= word_reg;
            end
            if (cmd.set_stat)
            begin
                stat_reg <= cmd.new_stat;
            end
            if (cmd.wback)
            begin
                // The memory result wins when both writes hit the same register.
                for (int i = 0; i < NREGS; i++)
                begin
                    if (dst_m == 4'(i))
                    begin
                        rf_reg[i] <= valm_reg;
                    end
                    else if (dst_e == 4'(i))
                    begin
                        rf_reg[i] <= vale_reg;
                    end
                end
                pc_reg <= newpc;
                if (icode == I_OPQ)
                begin
                    cc_reg <= ccn_reg;
                end
            end
        end
    end

    always_comb
    begin
        sts.clr_done  = clr_cnt_reg == AW'(MEM_BYTES - 1);
        sts.eng_done  = eng_done;
        sts.stat_ok   = stat_reg == ST_AOK;
        sts.pc_oob    = pc_reg >= 64'(MEM_BYTES);
        sts.icode_bad = icode > I_POP;
        sts.fetch_oob = ({1'b0, pc_reg} + {61'd0, len}) > 65'(MEM_BYTES);
        sts.halt      = icode == I_HALT;
        sts.fun_bad   = ((icode == I_CMOV || icode == I_JXX) && ifun > F_LAST_COND)
                        || (icode == I_OPQ && ifun > F_LAST_ALU);
        sts.has_regs  = has_regs;
        sts.need_c    = has_const;
        sts.mem_use   = icode inside {I_RMMOV, I_MRMOV, I_CALL, I_RET, I_PUSH, I_POP};
        sts.mem_rd    = icode inside {I_MRMOV, I_RET, I_POP};
        sts.data_oob  = maddr > 64'(MEM_BYTES - 8);
    end

    assign status        = stat_reg;
    assign prog_counter  = pc_reg;
    assign zero_flag     = cc_reg[0];
    assign sign_flag     = cc_reg[1];
    assign overflow_flag = cc_reg[2];
    assign read_value    = rv_reg;
    assign read_error    = err_reg;

endmodule

/* hdl/y86_ctrl.sv */
// Controller: sequences request handling and the phases of one instruction.
module y86_ctrl
    import y86_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_sts_t    sts
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.eng_base  = EB_REQ;
        cmd.eng_data  = ED_LOAD;
        cmd.rd_sel    = RS_PROBE;
        cmd.new_stat  = ST_AOK;
        in_ready      = 1'b0;
        out_valid     = 1'b0;

        case (state_reg)
            CS_CLEAR:
            begin
                cmd.clr_run = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = CS_IDLE;
                end
            end
            CS_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.req_latch = 1'b1;
                    case (req_type)
                        REQ_LOAD:
                        begin
                            cmd.eng_start = 1'b1;
                            cmd.eng_write = 1'b1;
                            cmd.eng_n     = 4'd1;
                            state_next    = CS_LOAD;
                        end
                        REQ_RREG:
                        begin
                            cmd.rv_reg_ld = 1'b1;
                            state_next    = CS_RESP;
                        end
                        REQ_RDQ:
                        begin
                            cmd.eng_start = 1'b1;
                            cmd.eng_n     = 4'd8;
                            state_next    = CS_RDQ;
                        end
                        default:
                        begin
                            if (!sts.stat_ok)
                            begin
                                state_next = CS_RESP;
                            end
                            else if (sts.pc_oob)
                            begin
                                cmd.set_stat = 1'b1;
                                cmd.new_stat = ST_ADR;
                                state_next   = CS_RESP;
                            end
                            else
                            begin
                                cmd.eng_start = 1'b1;
                                cmd.eng_n     = 4'd1;
                                cmd.eng_base  = EB_PC;
                                state_next    = CS_FETCH0;
                            end
                        end
                    endcase
                end
            end
            CS_LOAD:
            begin
                if (sts.eng_done)
                begin
                    state_next = CS_RESP;
                end
            end
            CS_RDQ:
            begin
                if (sts.eng_done)
                begin
                    cmd.rv_word_ld = 1'b1;
                    state_next     = CS_RESP;
                end
            end
            CS_FETCH0:
            begin
                if (sts.eng_done)
                begin
                    cmd.latch_ibyte = 1'b1;
                    state_next      = CS_DECODE;
                end
            end
            CS_DECODE:
            begin
                if (sts.icode_bad)
                begin
                    cmd.set_stat = 1'b1;
                    cmd.new_stat = ST_INS;
                    state_next   = CS_RESP;
                end
                else if (sts.fetch_oob)
                begin
                    cmd.set_stat = 1'b1;
                    cmd.new_stat = ST_ADR;
                    state_next   = CS_RESP;
                end
                else if (sts.halt)
                begin
                    cmd.set_stat = 1'b1;
                    cmd.new_stat = ST_HLT;
                    state_next   = CS_RESP;
                end
                else if (sts.fun_bad)
                begin
                    cmd.set_stat = 1'b1;
                    cmd.new_stat = ST_INS;
                    state_next   = CS_RESP;
                end
                else if (sts.has_regs)
                begin
                    cmd.eng_start = 1'b1;
                    cmd.eng_n     = 4'd1;
                    cmd.eng_base  = EB_PC1;
                    state_next    = CS_FREG;
                end
                else if (sts.need_c)
                begin
                    cmd.eng_start = 1'b1;
                    cmd.eng_n     = 4'd8;
                    cmd.eng_base  = EB_CONST;
                    state_next    = CS_FCONST;
                end
                else
                begin
                    state_next = CS_READA;
                end
            end
            CS_FREG:
            begin
                if (sts.eng_done)
                begin
                    cmd.latch_rbyte = 1'b1;
                    if (sts.need_c)
                    begin
                        cmd.eng_start = 1'b1;
                        cmd.eng_n     = 4'd8;
                        cmd.eng_base  = EB_CONST;
                        state_next    = CS_FCONST;
                    end
                    else
                    begin
                        state_next = CS_READA;
                    end
                end
            end
            CS_FCONST:
            begin
                if (sts.eng_done)
                begin
                    cmd.latch_valc = 1'b1;
                    state_next     = CS_READA;
                end
            end
            CS_READA:
            begin
                cmd.rd_sel     = RS_SRCA;
                cmd.latch_vala = 1'b1;
                state_next     = CS_READB;
            end
            CS_READB:
            begin
                cmd.rd_sel     = RS_SRCB;
                cmd.latch_valb = 1'b1;
                state_next     = CS_EXEC;
            end
            CS_EXEC:
            begin
                cmd.latch_exec = 1'b1;
                state_next     = CS_MEMCHK;
            end
            CS_MEMCHK:
            begin
                if (!sts.mem_use)
                begin
                    state_next = CS_WBACK;
                end
                else if (sts.data_oob)
                begin
                    cmd.set_stat = 1'b1;
                    cmd.new_stat = ST_ADR;
                    state_next   = CS_RESP;
                end
                else
                begin
                    cmd.eng_start = 1'b1;
                    cmd.eng_n     = 4'd8;
                    cmd.eng_base  = EB_DATA;
                    cmd.eng_data  = ED_STORE;
                    cmd.eng_write = !sts.mem_rd;
                    state_next    = sts.mem_rd ? CS_MEMRD : CS_MEMWR;
                end
            end
            CS_MEMRD:
            begin
                if (sts.eng_done)
                begin
                    cmd.latch_valm = 1'b1;
                    state_next     = CS_WBACK;
                end
            end
            CS_MEMWR:
            begin
                if (sts.eng_done)
                begin
                    state_next = CS_WBACK;
                end
            end
            CS_WBACK:
            begin
                cmd.wback  = 1'b1;
                state_next = CS_RESP;
            end
            CS_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

/* hdl/y86_sequential_cpu_step_core.sv */
// Top level of the sequential Y86-64 step core: controller plus datapath.
// All memory traffic goes through a single byte-wide port.
// Throughput: one item at a time; the next item is taken after the result is accepted.
// Reset: asynchronous and active low; afterwards a clearing pass zeroes the memory,
// one byte per cycle, before the first item is taken.
module y86_sequential_cpu_step_core
    import y86_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    y86_req_if.sink   req,
    y86_rsp_if.source rsp
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    y86_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .req_type  (req.req_type),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    y86_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .address       (req.address),
        .load_data     (req.load_data),
        .probe_reg     (req.probe_reg),
        .status        (rsp.status),
        .prog_counter  (rsp.prog_counter),
        .zero_flag     (rsp.zero_flag),
        .sign_flag     (rsp.sign_flag),
        .overflow_flag (rsp.overflow_flag),
        .read_value    (rsp.read_value),
        .read_error    (rsp.read_error)
    );

endmodule
